### design/text_console_writer_top_assert.svh
// Assertion macros for the text console writer checker.
// Needs clk and arst_n in scope where the macros are used.
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// same-cycle implication
`define TXC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TXC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/txc_pkg.sv
// Shared constants and types for the text console writer.
// No dependencies.
package txc_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);

	localparam int OPCODE_W     = 2;
	localparam int CHAR_W       = 8;
	localparam int LINE_W       = 5;
	localparam int INDEX_W      = 11;
	localparam int COLOR_W      = 8;
	localparam int CURSOR_COL_W = 7;
	localparam int CURSOR_ROW_W = 5;

	localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

	localparam logic [CHAR_W-1:0]  CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0]  CH_SPACE   = 8'd32;
	localparam logic [COLOR_W-1:0] COLOR_RST  = 8'd7;

	typedef struct packed {
		logic [COLOR_W-1:0] attr;
		logic [CHAR_W-1:0]  chr;
	} cell_t;

	localparam int CELL_W = $bits(cell_t);

endpackage

### design/txc_in_if.sv
// Input channel of the text console writer: valid/ready plus command fields.
// Depends on txc_pkg.
interface txc_in_if;
	import txc_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [CHAR_W-1:0]   char_code;
	logic                set_line;
	logic [LINE_W-1:0]   line;
	logic [INDEX_W-1:0]  cell_index;

	modport source (output valid, opcode, char_code, set_line, line, cell_index,
		input ready);
	modport sink (input valid, opcode, char_code, set_line, line, cell_index,
		output ready);
endinterface

### design/txc_out_if.sv
// Result channel of the text console writer: valid/ready plus result fields.
// Depends on txc_pkg.
interface txc_out_if;
	import txc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [CHAR_W-1:0]       read_char;
	logic [COLOR_W-1:0]      read_attr;
	logic [CURSOR_COL_W-1:0] cursor_col;
	logic [CURSOR_ROW_W-1:0] cursor_row;
	logic                    scrolled;

	modport source (output valid, read_char, read_attr, cursor_col, cursor_row, scrolled,
		input ready);
	modport sink (input valid, read_char, read_attr, cursor_col, cursor_row, scrolled,
		output ready);
endinterface

### design/txc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module txc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

### design/text_console_writer_top.sv
// Text console writer: cell store, cursor and sequencer for put/clear/read/scroll.
// Depends on txc_pkg, txc_in_if, txc_out_if and txc_ram.
//
// Usage: after reset the block walks the whole cell store once to blank it
// with in_ch.ready low; text_color writes are taken at any time. A put that
// does not scroll, a read outside the screen and the unused opcode raise
// their result straight from idle; a read in range passes ST_READ (registered
// RAM read). A clear writes every cell in ST_CLEAR; a put that scrolls copies
// rows up one in ST_COPY, then blanks the last row in ST_BLANK: the single RAM
// write port moves one cell per cycle. One command is worked at a time; a new
// one is taken as soon as the previous result has gone or is going.
module text_console_writer_top (
	input  logic                         clk,
	input  logic                         arst_n,
	txc_in_if.sink                       in_ch,
	txc_out_if.source                    out_ch,
	input  logic                         cfg_we,
	input  logic [txc_pkg::COLOR_W-1:0]  cfg_wdata
);
	import txc_pkg::*;

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_COPY  = 3'd3;
	localparam logic [2:0] ST_BLANK = 3'd4;
	localparam logic [2:0] ST_CLEAR = 3'd5;

	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(COPY_COUNT);

	logic [2:0]         state_q;
	logic [ADDR_W-1:0]  cnt_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [COLOR_W-1:0] color_q;
	logic               copy_s1;
	logic [ADDR_W-1:0]  copy_addr_s1;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  rd_char_q;
	logic [COLOR_W-1:0] rd_attr_q;
	logic               scrolled_q;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	cell_t              ram_wdata;
	logic [ADDR_W-1:0]  ram_raddr;
	cell_t              ram_rdata;

	logic               accept;
	logic               is_newline;
	logic [ROW_W-1:0]   row_eff;
	logic [ADDR_W-1:0]  put_pos;
	logic [COL_W:0]     col_inc;
	logic               wrap;
	logic [COL_W-1:0]   col_next;
	logic [ROW_W:0]     row_inc;
	logic               do_scroll;
	logic [ROW_W-1:0]   row_next;
	logic               idx_ok;

	assign in_ch.ready = (state_q == ST_IDLE) && (!out_valid_q || out_ch.ready);
	assign accept      = in_ch.valid && in_ch.ready;

	// cursor arithmetic for a put, and the index check for a read
	always_comb begin
		is_newline = (in_ch.char_code == CH_NEWLINE);
		if (in_ch.set_line) begin
			row_eff = (32'(in_ch.line) >= 32'(ROWS)) ? ROW_W'(ROWS - 1) : ROW_W'(in_ch.line);
		end else begin
			row_eff = row_q;
		end
		put_pos  = ADDR_W'(ADDR_W'(row_eff) * ADDR_W'(COLUMNS)) + ADDR_W'(col_q);
		col_inc  = {1'b0, col_q} + 1'b1;
		wrap     = (32'(col_inc) >= 32'(COLUMNS));
		col_next = (is_newline || wrap) ? '0 : col_inc[COL_W-1:0];
		row_inc  = {1'b0, row_eff} + ((is_newline || wrap) ? 1'b1 : 1'b0);
		do_scroll = (32'(row_inc) >= 32'(ROWS));
		row_next = do_scroll ? ROW_W'(ROWS - 1) : row_inc[ROW_W-1:0];
		idx_ok   = (32'(in_ch.cell_index) < 32'(CELL_COUNT));
	end

	// RAM port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = '{attr: color_q, chr: CH_SPACE};
		ram_raddr = ADDR_W'(in_ch.cell_index);
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = '{attr: COLOR_RST, chr: CH_SPACE};
			end
			ST_IDLE: begin
				ram_we    = accept && (in_ch.opcode == OP_PUT) && !is_newline;
				ram_waddr = put_pos;
				ram_wdata = '{attr: color_q, chr: in_ch.char_code};
			end
			ST_COPY: begin
				ram_we    = copy_s1;
				ram_waddr = copy_addr_s1;
				ram_wdata = ram_rdata;
				ram_raddr = cnt_q + ADDR_W'(COLUMNS);
			end
			ST_BLANK, ST_CLEAR: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	txc_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			cnt_q        <= '0;
			col_q        <= '0;
			row_q        <= '0;
			color_q      <= COLOR_RST;
			copy_s1      <= 1'b0;
			copy_addr_s1 <= '0;
			out_valid_q  <= 1'b0;
			rd_char_q    <= '0;
			rd_attr_q    <= '0;
			scrolled_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				color_q <= cfg_wdata;
			end
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			copy_s1      <= (state_q == ST_COPY) && (cnt_q < COPY_END);
			copy_addr_s1 <= cnt_q;

			case (state_q)
				ST_INIT: begin
					if (cnt_q == LAST_CELL) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						rd_char_q  <= '0;
						rd_attr_q  <= '0;
						scrolled_q <= 1'b0;
						case (in_ch.opcode)
							OP_PUT: begin
								col_q <= col_next;
								row_q <= row_next;
								if (do_scroll) begin
									cnt_q   <= '0;
									state_q <= ST_COPY;
								end else begin
									out_valid_q <= 1'b1;
								end
							end
							OP_CLEAR: begin
								cnt_q   <= '0;
								state_q <= ST_CLEAR;
							end
							OP_READ: begin
								if (idx_ok) begin
									state_q <= ST_READ;
								end else begin
									out_valid_q <= 1'b1;
								end
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_READ: begin
					rd_char_q   <= ram_rdata.chr;
					rd_attr_q   <= ram_rdata.attr;
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_COPY: begin
					// last cycle only retires the final pending copy
					if (cnt_q == COPY_END) begin
						state_q <= ST_BLANK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_BLANK: begin
					if (cnt_q == LAST_CELL) begin
						scrolled_q  <= 1'b1;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_CLEAR: begin
					if (cnt_q == LAST_CELL) begin
						col_q       <= '0;
						row_q       <= '0;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.read_char  = rd_char_q;
	assign out_ch.read_attr  = rd_attr_q;
	assign out_ch.cursor_col = CURSOR_COL_W'(col_q);
	assign out_ch.cursor_row = CURSOR_ROW_W'(row_q);
	assign out_ch.scrolled   = scrolled_q;
endmodule

### design/txc_checker.sv
// Port-level checks on the text console writer, bound to the top level.
// Depends on txc_pkg and text_console_writer_top_assert.svh.
`include "text_console_writer_top_assert.svh"

module txc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [txc_pkg::CHAR_W-1:0]         read_char,
	input logic [txc_pkg::COLOR_W-1:0]        read_attr,
	input logic [txc_pkg::CURSOR_COL_W-1:0]   cursor_col,
	input logic [txc_pkg::CURSOR_ROW_W-1:0]   cursor_row,
	input logic                               scrolled
);
	import txc_pkg::*;

	`TXC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_char) && $stable(read_attr) && $stable(cursor_col) && $stable(cursor_row) && $stable(scrolled), "result dropped or changed while stalled")
	`TXC_ASSERT_NOW(a_col_range, out_valid, 32'(cursor_col) < 32'(COLUMNS) || COLUMNS > 128, "cursor column off screen")
	`TXC_ASSERT_NOW(a_row_range, out_valid, 32'(cursor_row) < 32'(ROWS) || ROWS > 32, "cursor row off screen")
	`TXC_ASSERT_NOW(a_scroll_pos, out_valid && scrolled, cursor_col == '0 && cursor_row == CURSOR_ROW_W'(ROWS - 1) && read_char == '0 && read_attr == '0, "scroll result inconsistent")
endmodule

bind text_console_writer_top txc_checker u_txc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.read_char  (out_ch.read_char),
	.read_attr  (out_ch.read_attr),
	.cursor_col (out_ch.cursor_col),
	.cursor_row (out_ch.cursor_row),
	.scrolled   (out_ch.scrolled)
);

### test/text_console_writer_top_tb.sv
// Testbench for text_console_writer_top: puts, newlines, scrolls, clears and reads.
// Results are checked against a cycle-free model of the cell store and cursor.
// Depends on txc_pkg, txc_in_if, txc_out_if and the RTL of the block.
module text_console_writer_top_tb;
	import txc_pkg::*;

	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [CHAR_W-1:0]       rd_chr;
		logic [COLOR_W-1:0]      rd_attr;
		logic [CURSOR_COL_W-1:0] col;
		logic [CURSOR_ROW_W-1:0] row;
		logic                    scrolled;
	} console_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [COLOR_W-1:0] cfg_wdata;

	txc_in_if  in_ch();
	txc_out_if out_ch();

	text_console_writer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	cell_t              screen [CELL_COUNT];
	int                 cur_col;
	int                 cur_row;
	logic [COLOR_W-1:0] text_colour;
	console_result_t    console_q[$];
	int                 fault_cnt = 0;
	int                 idle_cycles = 0;
	bit                 steady;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic console_result_t predict_step(input logic [OPCODE_W-1:0] op,
		input logic [CHAR_W-1:0] ch, input logic sl, input logic [LINE_W-1:0] ln,
		input logic [INDEX_W-1:0] idx);
		console_result_t r;
		int pos;
		r = '0;
		case (op)
			OP_PUT: begin
				if (sl)
					cur_row = (ln >= ROWS) ? ROWS - 1 : int'(ln);
				if (ch == CH_NEWLINE) begin
					cur_col = 0;
					cur_row++;
				end else begin
					pos = cur_row * COLUMNS + cur_col;
					if (pos < CELL_COUNT)
						screen[pos] = '{attr: text_colour, chr: ch};
					cur_col++;
					if (cur_col >= COLUMNS) begin
						cur_col = 0;
						cur_row++;
					end
				end
				if (cur_row >= ROWS) begin
					for (int i = 0; i < COPY_COUNT; i++)
						screen[i] = screen[i + COLUMNS];
					for (int i = COPY_COUNT; i < CELL_COUNT; i++)
						screen[i] = '{attr: text_colour, chr: CH_SPACE};
					if (cur_row > 0)
						cur_row--;
					r.scrolled = 1'b1;
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < CELL_COUNT; i++)
					screen[i] = '{attr: text_colour, chr: CH_SPACE};
				cur_col = 0;
				cur_row = 0;
			end
			OP_READ: begin
				if (idx < CELL_COUNT) begin
					r.rd_chr  = screen[idx].chr;
					r.rd_attr = screen[idx].attr;
				end
			end
			default: ;
		endcase
		r.col = cur_col[CURSOR_COL_W-1:0];
		r.row = cur_row[CURSOR_ROW_W-1:0];
		return r;
	endfunction

	task automatic note_fault(input string what);
		if (fault_cnt < 10)
			$display("%s", what);
		fault_cnt++;
	endtask

	// valid is left high after a transfer so a zero gap gives back-to-back items
	task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] ch,
		input logic sl, input logic [LINE_W-1:0] ln, input logic [INDEX_W-1:0] idx);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.opcode     <= op;
		in_ch.char_code  <= ch;
		in_ch.set_line   <= sl;
		in_ch.line       <= ln;
		in_ch.cell_index <= idx;
		do @(posedge clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
		console_q.push_back(predict_step(op, ch, sl, ln, idx));
	endtask

	task automatic put_char(input logic [CHAR_W-1:0] ch, input logic sl,
		input logic [LINE_W-1:0] ln);
		send_cmd(OP_PUT, ch, sl, ln, INDEX_W'($urandom_range(0, 2047)));
	endtask

	task automatic read_cell(input logic [INDEX_W-1:0] idx);
		send_cmd(OP_READ, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			LINE_W'($urandom_range(0, 31)), idx);
	endtask

	task automatic clear_screen;
		send_cmd(OP_CLEAR, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			LINE_W'($urandom_range(0, 31)), INDEX_W'($urandom_range(0, 2047)));
	endtask

	task automatic send_unused;
		send_cmd(OP_UNUSED, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			LINE_W'($urandom_range(0, 31)), INDEX_W'($urandom_range(0, 2047)));
	endtask

	// only once the block has drained every result
	task automatic write_colour(input logic [COLOR_W-1:0] v);
		in_ch.valid <= 1'b0;
		while (console_q.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we      <= 1'b0;
		text_colour = v;
	endtask

	task automatic test_put_extremes;
		put_char(8'h00, 1'b0, 5'd0);
		put_char(8'hFF, 1'b0, 5'd0);
		put_char(8'h41, 1'b0, 5'd31);
		read_cell(11'd0);
		read_cell(11'd1);
		read_cell(11'd2);
		read_cell(11'd3);
	endtask

	task automatic test_row_clamp;
		put_char(8'h7E, 1'b1, 5'd31);
		put_char(8'h7F, 1'b1, 5'd25);
		read_cell(INDEX_W'(24 * COLUMNS + 3));
	endtask

	task automatic test_scroll;
		write_colour(8'hFF);
		put_char(CH_NEWLINE, 1'b1, 5'd24);
		put_char(CH_NEWLINE, 1'b1, 5'd30);
		read_cell(INDEX_W'(22 * COLUMNS + 3));
		read_cell(INDEX_W'(24 * COLUMNS));
	endtask

	task automatic test_read_bounds;
		read_cell(INDEX_W'(CELL_COUNT - 1));
		read_cell(INDEX_W'(CELL_COUNT));
		read_cell(11'h7FF);
		send_unused();
	endtask

	task automatic test_clear;
		write_colour(8'h00);
		clear_screen();
		read_cell(INDEX_W'(22 * COLUMNS + 3));
		put_char(8'h55, 1'b0, 5'd0);
		read_cell(11'd0);
	endtask

	// lines of text with random content, reads around the cursor row, some noise
	task automatic test_random_text;
		logic [COLOR_W-1:0] colours [4];
		int sent;
		int len;
		int nrd;
		logic sl;
		logic [LINE_W-1:0] ln;
		colours = '{8'h00, 8'hFF, COLOR_W'($urandom_range(0, 255)),
			COLOR_W'($urandom_range(0, 255))};
		for (int ph = 0; ph < 4; ph++) begin
			write_colour(colours[ph]);
			clear_screen();
			sent = 1;
			while (sent < 500) begin
				steady = ($urandom_range(0, 9) == 0);
				if ($urandom_range(0, 99) < 3) begin
					clear_screen();
					sent++;
				end
				if ($urandom_range(0, 99) < 5)
					send_unused();
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100)
					: $urandom_range(1, 20);
				for (int k = 0; k < len; k++) begin
					sl = (k == 0) && ($urandom_range(0, 1) == 1);
					ln = ($urandom_range(0, 2) == 0) ? LINE_W'($urandom_range(20, 31))
						: LINE_W'($urandom_range(0, 31));
					if ($urandom_range(0, 99) < 3)
						put_char(CH_NEWLINE, sl, ln);
					else
						put_char(CHAR_W'($urandom_range(0, 255)), sl, ln);
				end
				sent += len;
				if ($urandom_range(0, 3) != 0) begin
					put_char(CH_NEWLINE, 1'b0, LINE_W'($urandom_range(0, 31)));
					sent++;
				end
				nrd = $urandom_range(1, 3);
				for (int k = 0; k < nrd; k++) begin
					case ($urandom_range(0, 3))
						0, 1: read_cell(INDEX_W'((cur_row > 0 ? cur_row - 1 : cur_row)
							* COLUMNS + $urandom_range(0, COLUMNS - 1)));
						2: read_cell(INDEX_W'($urandom_range(0, CELL_COUNT - 1)));
						default: read_cell(INDEX_W'($urandom_range(0, 2047)));
					endcase
				end
				sent += nrd;
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		int stall;
		out_ch.ready = 1'b0;
		forever begin
			stall = steady ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
		end
	end

	always @(posedge clk) begin
		console_result_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (console_q.size() == 0) begin
				note_fault("result transfer with nothing expected");
			end else begin
				want = console_q.pop_front();
				if (want.rd_chr !== out_ch.read_char || want.rd_attr !== out_ch.read_attr
					|| want.col !== out_ch.cursor_col || want.row !== out_ch.cursor_row
					|| want.scrolled !== out_ch.scrolled)
					note_fault($sformatf(
						"mismatch: exp chr %h attr %h col %0d row %0d scr %b, got %h %h %0d %0d %b",
						want.rd_chr, want.rd_attr, want.col, want.row, want.scrolled,
						out_ch.read_char, out_ch.read_attr, out_ch.cursor_col,
						out_ch.cursor_row, out_ch.scrolled));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
			|| (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("text_console_writer_top_tb: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		in_ch.valid      = 1'b0;
		in_ch.opcode     = OP_PUT;
		in_ch.char_code  = '0;
		in_ch.set_line   = 1'b0;
		in_ch.line       = '0;
		in_ch.cell_index = '0;
		steady           = 1'b0;
		text_colour      = COLOR_RST;
		cur_col          = 0;
		cur_row          = 0;
		for (int i = 0; i < CELL_COUNT; i++)
			screen[i] = '{attr: COLOR_RST, chr: CH_SPACE};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// block blanks its store after reset before it takes anything
		while (in_ch.ready !== 1'b1) @(posedge clk);

		test_put_extremes();
		test_row_clamp();
		test_scroll();
		test_read_bounds();
		test_clear();
		test_random_text();

		in_ch.valid <= 1'b0;
		while (console_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fault_cnt == 0)
			$display("text_console_writer_top_tb: done, clean");
		else
			$display("text_console_writer_top_tb: done, errors");
		$finish;
	end

endmodule

### files.f
+incdir+design
design/txc_pkg.sv
design/txc_in_if.sv
design/txc_out_if.sv
design/txc_ram.sv
design/text_console_writer_top.sv
design/txc_checker.sv
test/text_console_writer_top_tb.sv
